### rtl/rmth_pkg.sv
// Package for the running median block: widths, sizes, state types and
// the request/status structs shared by the heap unit and the controller.
// No dependencies.
package rmth_pkg;

  localparam int VALUE_W    = 32;
  localparam int SUM_W      = 16;
  localparam int CNT_W      = 11;
  localparam int CAPACITY   = 1024;
  localparam int HEAP_DEPTH = CAPACITY / 2 + 1;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int DIV_W      = SUM_W + 1;
  localparam int DIVD_W     = VALUE_W;
  localparam int STEP_W     = $clog2(DIVD_W + 1);
  localparam logic [SUM_W-1:0] DEFAULT_MODULUS = SUM_W'(10000);

  typedef enum logic [2:0] {
    H_IDLE,
    H_PUSH_RD,
    H_PUSH_CMP,
    H_POP_LAST,
    H_POP_RDL,
    H_POP_RDR,
    H_POP_CMP
  } heap_state_t;

  typedef enum logic [3:0] {
    C_IDLE,
    C_INSERT,
    C_WAIT_INS,
    C_WAIT_POP,
    C_WAIT_PUSH,
    C_MEDIAN,
    C_MOD_MED,
    C_MOD_SUM,
    C_OUT
  } ctl_state_t;

  typedef struct packed {
    logic                      clear;
    logic                      push;
    logic                      pop;
    logic signed [VALUE_W-1:0] value;
  } heap_cmd_t;

  typedef struct packed {
    logic                      busy;
    logic [ADDR_W-1:0]         size;
    logic signed [VALUE_W-1:0] top;
  } heap_stat_t;

  // a sits above b in heap order
  function automatic logic above(input logic signed [VALUE_W-1:0] a,
                                 input logic signed [VALUE_W-1:0] b,
                                 input logic is_max);
    above = is_max ? (a > b) : (a < b);
  endfunction

endpackage

### rtl/rmth_heap.sv
// One binary heap in a single-port-read, single-port-write memory, with an
// iterative sift sequencer for push and pop. Top of heap is mirrored in a register.
// Depends on rmth_pkg.
module rmth_heap (
  input  logic                clk,
  input  logic                rst,
  input  logic                max_heap,
  input  rmth_pkg::heap_cmd_t cmd,
  output rmth_pkg::heap_stat_t stat
);
  import rmth_pkg::*;

  logic signed [VALUE_W-1:0] mem [HEAP_DEPTH];

  heap_state_t state, state_next;
  logic [ADDR_W-1:0] size, size_next, idx, idx_next;
  logic signed [VALUE_W-1:0] val, val_next, lval, lval_next, rd_data, top;
  logic has_right, has_right_next;

  logic rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr, parent;
  logic signed [VALUE_W-1:0] wr_data, cval;
  logic [ADDR_W:0] lchild, rchild;
  logic pick_right;

  assign lchild     = {idx, 1'b1};
  assign rchild     = lchild + 1'b1;
  assign parent     = (idx - 1'b1) >> 1;
  assign pick_right = has_right && above(rd_data, lval, max_heap);
  assign cval       = pick_right ? rd_data : lval;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      size  <= '0;
    end else begin
      state <= state_next;
      size  <= size_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    val       <= val_next;
    lval      <= lval_next;
    has_right <= has_right_next;
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_en && wr_addr == '0) begin
      top <= wr_data;
    end
  end

  always_comb begin
    state_next     = state;
    size_next      = size;
    idx_next       = idx;
    val_next       = val;
    lval_next      = lval;
    has_right_next = has_right;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = idx;
    wr_data        = val;
    case (state)
      H_IDLE: begin
        if (cmd.clear) begin
          size_next = '0;
        end else if (cmd.push) begin
          val_next   = cmd.value;
          idx_next   = size;
          size_next  = size + 1'b1;
          state_next = H_PUSH_RD;
        end else if (cmd.pop && size != '0) begin
          size_next = size - 1'b1;
          idx_next  = '0;
          rd_en     = 1'b1;
          rd_addr   = size - 1'b1;
          if (size != ADDR_W'(1)) begin
            state_next = H_POP_LAST;
          end
        end
      end
      H_PUSH_RD: begin
        if (idx == '0) begin
          wr_en      = 1'b1;
          state_next = H_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = parent;
          state_next = H_PUSH_CMP;
        end
      end
      H_PUSH_CMP: begin
        wr_en = 1'b1;
        if (above(val, rd_data, max_heap)) begin
          wr_data    = rd_data;
          idx_next   = parent;
          state_next = H_PUSH_RD;
        end else begin
          state_next = H_IDLE;
        end
      end
      H_POP_LAST: begin
        val_next   = rd_data;
        state_next = H_POP_RDL;
      end
      H_POP_RDL: begin
        if (lchild >= {1'b0, size}) begin
          wr_en      = 1'b1;
          state_next = H_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = lchild[ADDR_W-1:0];
          state_next = H_POP_RDR;
        end
      end
      H_POP_RDR: begin
        lval_next      = rd_data;
        has_right_next = rchild < {1'b0, size};
        rd_en          = 1'b1;
        rd_addr        = rchild[ADDR_W-1:0];
        state_next     = H_POP_CMP;
      end
      H_POP_CMP: begin
        wr_en = 1'b1;
        if (above(cval, val, max_heap)) begin
          wr_data    = cval;
          idx_next   = pick_right ? rchild[ADDR_W-1:0] : lchild[ADDR_W-1:0];
          state_next = H_POP_RDL;
        end else begin
          state_next = H_IDLE;
        end
      end
      default: state_next = H_IDLE;
    endcase
  end

  assign stat.busy = (state != H_IDLE);
  assign stat.size = size;
  assign stat.top  = top;

endmodule

### rtl/rmth_mod.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on rmth_pkg.
module rmth_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rmth_pkg::DIVD_W-1:0] dividend,
  input  logic [rmth_pkg::DIV_W-1:0]  divisor,
  output logic                        busy,
  output logic [rmth_pkg::DIV_W-1:0]  rem
);
  import rmth_pkg::*;

  logic [DIVD_W-1:0] shreg;
  logic [DIV_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic [DIV_W:0]    trial;

  assign trial = {rem, shreg[DIVD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && steps == STEP_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
      steps <= STEP_W'(DIVD_W);
    end else if (busy) begin
      shreg <= shreg << 1;
      steps <= steps - 1'b1;
      if (trial >= {1'b0, dvs}) begin
        rem <= DIV_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DIV_W-1:0];
      end
    end
  end

endmodule

### rtl/running_median_two_heaps.sv
// Running median over a stream of signed 32-bit samples, kept in a max-heap
// (lower half) and a min-heap (upper half) of 513 entries each. Every request
// produces one result: median (lower median for even counts), running sum of
// medians modulo sum_modulus (0 means 65536), count held, and a full flag when
// 1024 values are stored and the sample is dropped. A request runs the insert,
// a rebalancing pop and push when the heaps are out of balance, and two passes
// of the bit-serial remainder unit; a dropped sample skips the remainder unit.
// Depends on rmth_pkg, rmth_heap, rmth_mod.
module running_median_two_heaps (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // sum_modulus
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] sample
  input  logic        s_axis_tuser,  // start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // [31:0] median, [47:32] median_sum, [58:48] stored_count
  output logic        m_axis_tuser   // full_res
);
  import rmth_pkg::*;

  ctl_state_t state, state_next;
  heap_cmd_t  lo_cmd, up_cmd;
  heap_stat_t lo_stat, up_stat;

  logic [SUM_W-1:0] modulus, sum_acc;
  logic signed [VALUE_W-1:0] sample, med, moved;
  logic full, move_up;
  logic [CNT_W-1:0] count;
  logic [DIV_W-1:0] mod_eff, mod_rem, r_fixed;
  logic mod_start, mod_busy;
  logic [DIVD_W-1:0] mod_dividend;
  logic s_acc;

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign count   = CNT_W'(lo_stat.size) + CNT_W'(up_stat.size);
  assign mod_eff = (modulus == '0) ? {1'b1, {SUM_W{1'b0}}} : {1'b0, modulus};
  assign r_fixed = (med[VALUE_W-1] && mod_rem != '0) ? mod_eff - mod_rem : mod_rem;

  rmth_heap u_lower (.clk, .rst, .max_heap(1'b1), .cmd(lo_cmd), .stat(lo_stat));
  rmth_heap u_upper (.clk, .rst, .max_heap(1'b0), .cmd(up_cmd), .stat(up_stat));

  rmth_mod u_mod (
    .clk, .rst, .start(mod_start), .dividend(mod_dividend),
    .divisor(mod_eff), .busy(mod_busy), .rem(mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= C_IDLE;
      modulus <= DEFAULT_MODULUS;
      sum_acc <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        modulus <= cfg_wr_data;
      end
      if (s_acc && s_axis_tuser) begin
        sum_acc <= '0;
      end else if (state == C_MOD_SUM && !mod_busy) begin
        sum_acc <= mod_rem[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      sample <= s_axis_tdata;
      full   <= 1'b0;
    end
    if (state == C_INSERT && count >= CNT_W'(CAPACITY)) begin
      full <= 1'b1;
    end
    if (state == C_WAIT_INS && !lo_stat.busy && !up_stat.busy) begin
      move_up <= lo_stat.size > up_stat.size + 1'b1;
      moved   <= (lo_stat.size > up_stat.size + 1'b1) ? lo_stat.top : up_stat.top;
    end
    if (state == C_MEDIAN) begin
      med <= (lo_stat.size != '0) ? lo_stat.top : '0;
    end
  end

  always_comb begin
    state_next   = state;
    lo_cmd       = '0;
    up_cmd       = '0;
    lo_cmd.value = sample;
    up_cmd.value = sample;
    mod_start    = 1'b0;
    mod_dividend = med[VALUE_W-1] ? DIVD_W'(-med) : DIVD_W'(med);
    case (state)
      C_IDLE: begin
        if (s_acc) begin
          lo_cmd.clear = s_axis_tuser;
          up_cmd.clear = s_axis_tuser;
          state_next   = C_INSERT;
        end
      end
      C_INSERT: begin
        if (count >= CNT_W'(CAPACITY)) begin
          state_next = C_MEDIAN;
        end else begin
          if (lo_stat.size == '0 || sample <= lo_stat.top) begin
            lo_cmd.push = 1'b1;
          end else begin
            up_cmd.push = 1'b1;
          end
          state_next = C_WAIT_INS;
        end
      end
      C_WAIT_INS: begin
        if (!lo_stat.busy && !up_stat.busy) begin
          if (lo_stat.size > up_stat.size + 1'b1) begin
            lo_cmd.pop = 1'b1;
            state_next = C_WAIT_POP;
          end else if (up_stat.size > lo_stat.size) begin
            up_cmd.pop = 1'b1;
            state_next = C_WAIT_POP;
          end else begin
            state_next = C_MEDIAN;
          end
        end
      end
      C_WAIT_POP: begin
        lo_cmd.value = moved;
        up_cmd.value = moved;
        if (!lo_stat.busy && !up_stat.busy) begin
          up_cmd.push = move_up;
          lo_cmd.push = !move_up;
          state_next  = C_WAIT_PUSH;
        end
      end
      C_WAIT_PUSH: begin
        if (!lo_stat.busy && !up_stat.busy) begin
          state_next = C_MEDIAN;
        end
      end
      C_MEDIAN: begin
        state_next = full ? C_OUT : C_MOD_MED;
        mod_start  = !full;
        mod_dividend = (lo_stat.size == '0) ? '0 :
                       lo_stat.top[VALUE_W-1] ? DIVD_W'(-lo_stat.top) : DIVD_W'(lo_stat.top);
      end
      C_MOD_MED: begin
        mod_dividend = DIVD_W'({1'b0, sum_acc} + r_fixed);
        if (!mod_busy) begin
          mod_start  = 1'b1;
          state_next = C_MOD_SUM;
        end
      end
      C_MOD_SUM: begin
        if (!mod_busy) begin
          state_next = C_OUT;
        end
      end
      C_OUT: begin
        if (m_axis_tready) begin
          state_next = C_IDLE;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end

  assign s_axis_tready = (state == C_IDLE);
  assign m_axis_tvalid = (state == C_OUT);
  assign m_axis_tdata  = {5'b0, count, sum_acc, med};
  assign m_axis_tuser  = full;

  a_idle_heaps: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !lo_stat.busy && !up_stat.busy && !mod_busy)
    else $error("heap or remainder unit busy while taking a request");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> count <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_balanced: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (lo_stat.size == up_stat.size || lo_stat.size == up_stat.size + 1'b1))
    else $error("heaps out of balance at result");

  a_full_sum: assert property (@(posedge clk) disable iff (rst)
    (state == C_OUT && full && !$past(s_acc)) |-> $stable(sum_acc))
    else $error("sum changed on a dropped sample");

endmodule
